### hw/rtl/sms_pkg.sv
// package for the submask count multiset block
// shared constants, operation codes, sequencer states and the step struct
// no dependencies
`default_nettype none

package sms_pkg;

   // default sizes, overridable at the top level
   localparam int MASK_BITS_DEF  = 16;
   localparam int COUNT_BITS_DEF = 20;

   // fixed field widths of the stream items
   localparam int MODE_BITS      = 2;
   localparam int VALUE_BITS     = 16;
   localparam int COUNT_OUT_BITS = 20;
   localparam int REQ_DATA_BITS  = 24;
   localparam int RSP_DATA_BITS  = 24;

   typedef enum logic [1:0] {
      MODE_ADD   = 2'd0,
      MODE_DEL   = 2'd1,
      MODE_COUNT = 2'd2
   } mode_type;

   // what one step of the walk does to the tables and accumulator
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_UPD_EXACT,
      OP_UPD_SUB,
      OP_UPD_SUP,
      OP_UPD_TOTAL,
      OP_ACC_EXACT,
      OP_ACC_SUB,
      OP_ACC_SUP,
      OP_RESULT
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic   valid;
      op_type op;
      logic   neg;         // subtract instead of add
      logic   first;       // first accumulate step of a count
      logic   from_total;  // accumulator starts from the low total
   } step_type;

endpackage

`default_nettype wire

### hw/rtl/submask_count_multiset_top.sv
// submask count multiset: add, delete or count items over a table of bit masks
// a walk visits the 2^k submasks of a base mask, k = popcount of the value when
// it has at most MASK_BITS/2 ones, else its number of zeros; at most 2^(MASK_BITS/2) submasks
// one table step per cycle on one write port each; a new item waits until the last walk ends
// the next item is taken while a count result waits; a count finishes only once the result register is empty
// reset: synchronous, then a clearing pass over all 2^MASK_BITS addresses with req_tready low
`default_nettype none

module submask_count_multiset_top
   import sms_pkg::*;
#(
   parameter int MASK_BITS  = MASK_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request items
   input  wire logic                     req_tvalid,
   output      logic                     req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,  // mode[1:0], value[17:2], zero pad
   // result items, one per count
   output      logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   output      logic [RSP_DATA_BITS-1:0] rsp_tdata   // count[19:0], zero pad
);

   logic [MODE_BITS-1:0]      req_mode;
   logic [VALUE_BITS-1:0]     req_value;
   logic [MASK_BITS-1:0]      req_mask;
   step_type                  step;
   logic [MASK_BITS-1:0]      step_addr;
   logic                      res_valid;
   logic [COUNT_BITS-1:0]     res_data;
   logic [COUNT_OUT_BITS-1:0] res_count;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COUNT_OUT_BITS-1:0] rsp_count_ff, rsp_count_in;

   // unpack the request item
   assign req_mode  = req_tdata[MODE_BITS-1:0];
   assign req_value = req_tdata[MODE_BITS +: VALUE_BITS];

   // value taken to the mask width
   generate
      if (MASK_BITS <= VALUE_BITS) begin : g_mask_trunc
         assign req_mask = req_value[MASK_BITS-1:0];
      end else begin : g_mask_ext
         assign req_mask = {{(MASK_BITS-VALUE_BITS){1'b0}}, req_value};
      end
   endgenerate

   // counter taken to the result field width
   generate
      if (COUNT_BITS >= COUNT_OUT_BITS) begin : g_cnt_trunc
         assign res_count = res_data[COUNT_OUT_BITS-1:0];
      end else begin : g_cnt_ext
         assign res_count = {{(COUNT_OUT_BITS-COUNT_BITS){1'b0}}, res_data};
      end
   endgenerate

   // sequencer: clearing pass, then submask or superset walk per item
   sms_seq #(.MASK_BITS(MASK_BITS)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_mode  (req_mode),
      .req_mask  (req_mask),
      .rsp_busy  (rsp_valid_ff),
      .step      (step),
      .step_addr (step_addr)
   );

   // counter memories, low total and the shared add/subtract unit
   sms_tables #(.MASK_BITS(MASK_BITS), .COUNT_BITS(COUNT_BITS)) u_tables (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .step_addr (step_addr),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   // result register; the sequencer only finishes a count when it is empty
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = res_count;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS-COUNT_OUT_BITS){1'b0}}, rsp_count_ff};

endmodule

`default_nettype wire

### hw/rtl/sms_alu.sv
// shared add/subtract unit of the submask count multiset block
// modular sum or difference of two counter-wide operands
// depends on nothing but its parameter
`default_nettype none

module sms_alu #(
   parameter int COUNT_BITS = 20
) (
   input  wire logic [COUNT_BITS-1:0] opa,
   input  wire logic [COUNT_BITS-1:0] opb,
   input  wire logic                  neg,
   output      logic [COUNT_BITS-1:0] sum
);

   logic [COUNT_BITS-1:0] opb_eff;

   // two's complement subtract: invert and carry in
   assign opb_eff = opb ^ {COUNT_BITS{neg}};
   assign sum     = opa + opb_eff + {{(COUNT_BITS-1){1'b0}}, neg};

endmodule

`default_nettype wire

### hw/rtl/sms_seq.sv
// sequencer of the submask count multiset block
// clears the tables after reset, then walks submasks one step a cycle
// depends on sms_pkg
`default_nettype none

module sms_seq
   import sms_pkg::*;
#(
   parameter int MASK_BITS = MASK_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire logic [1:0]           req_mode,
   input  wire logic [MASK_BITS-1:0] req_mask,
   input  wire logic                 rsp_busy,
   output      step_type             step,
   output      logic [MASK_BITS-1:0] step_addr
);

   localparam int HALF_BITS = MASK_BITS / 2;

   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic                 low_ff, low_in;
   logic [MASK_BITS-1:0] mask_ff, mask_in;
   logic [MASK_BITS-1:0] base_ff, base_in;
   logic [MASK_BITS-1:0] sub_ff, sub_in;
   step_type             step_ff, step_in;
   logic [MASK_BITS-1:0] addr_ff, addr_in;

   logic                 accept;
   logic                 req_low;
   logic [MASK_BITS-1:0] req_base;
   logic                 mode_ok;
   logic                 sub_zero;
   logic                 is_update;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_low   = ($countones(req_mask) <= HALF_BITS);
   assign req_base  = req_low ? req_mask : ~req_mask;
   assign mode_ok   = (req_mode == MODE_ADD) || (req_mode == MODE_DEL) ||
                      (req_mode == MODE_COUNT);
   assign sub_zero  = (sub_ff == '0);
   assign is_update = (mode_ff == MODE_ADD) || (mode_ff == MODE_DEL);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sub_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && mode_ok) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (sub_zero) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!(mode_ff == MODE_COUNT && rsp_busy)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // item registers and submask walk
   always_comb begin
      mode_in = mode_ff;
      low_in  = low_ff;
      mask_in = mask_ff;
      base_in = base_ff;
      sub_in  = sub_ff;
      case (state_ff)
         ST_CLEAR: sub_in = sub_ff + {{(MASK_BITS-1){1'b0}}, 1'b1};
         ST_IDLE: begin
            if (accept && mode_ok) begin
               mode_in = mode_type'(req_mode);
               low_in  = req_low;
               mask_in = req_mask;
               base_in = req_base;
               sub_in  = req_base;
            end
         end
         ST_WALK: sub_in = (sub_ff - {{(MASK_BITS-1){1'b0}}, 1'b1}) & base_ff;
         default: sub_in = sub_ff;
      endcase
   end

   // step issued to the tables
   always_comb begin
      step_in  = '{valid: 1'b0, op: OP_NONE, neg: 1'b0, first: 1'b0, from_total: 1'b0};
      addr_in  = sub_ff;
      case (state_ff)
         ST_CLEAR: begin
            step_in.valid = 1'b1;
            step_in.op    = OP_CLEAR;
         end
         ST_WALK: begin
            step_in.valid = 1'b1;
            case (mode_ff)
               MODE_ADD, MODE_DEL: begin
                  step_in.neg = (mode_ff == MODE_DEL);
                  if (!low_ff) begin
                     step_in.op = OP_UPD_SUP;
                     addr_in    = sub_ff | mask_ff;
                  end else if (!sub_zero) begin
                     step_in.op = OP_UPD_SUB;
                  end else begin
                     // exact counter of the value itself rides on the empty submask
                     step_in.op = OP_UPD_EXACT;
                     addr_in    = mask_ff;
                  end
               end
               MODE_COUNT: begin
                  step_in.first      = (sub_ff == base_ff);
                  step_in.from_total = !low_ff;
                  if (low_ff) begin
                     step_in.op = OP_ACC_EXACT;
                  end else if (!sub_zero) begin
                     // inclusion-exclusion: odd submasks subtract
                     step_in.op  = OP_ACC_SUB;
                     step_in.neg = ^sub_ff;
                  end else begin
                     step_in.op = OP_ACC_SUP;
                     addr_in    = mask_ff;
                  end
               end
               default: step_in.valid = 1'b0;
            endcase
         end
         ST_FINISH: begin
            if (mode_ff == MODE_COUNT) begin
               step_in.valid = !rsp_busy;
               step_in.op    = OP_RESULT;
            end else if (is_update && low_ff) begin
               step_in.valid = 1'b1;
               step_in.op    = OP_UPD_TOTAL;
               step_in.neg   = (mode_ff == MODE_DEL);
            end
         end
         default: step_in.valid = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         sub_ff        <= '0;
         step_ff.valid <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sub_ff        <= sub_in;
         step_ff.valid <= step_in.valid;
      end
      mode_ff            <= mode_in;
      low_ff             <= low_in;
      mask_ff            <= mask_in;
      base_ff            <= base_in;
      step_ff.op         <= step_in.op;
      step_ff.neg        <= step_in.neg;
      step_ff.first      <= step_in.first;
      step_ff.from_total <= step_in.from_total;
      addr_ff            <= addr_in;
   end

   assign step      = step_ff;
   assign step_addr = addr_ff;

endmodule

`default_nettype wire

### hw/rtl/sms_tables.sv
// counter tables, low total and accumulator of the submask count multiset block
// three single-port-write memories with registered reads, one step per cycle
// depends on sms_pkg and sms_alu
`default_nettype none

module sms_tables
   import sms_pkg::*;
#(
   parameter int MASK_BITS  = MASK_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire step_type              step,
   input  wire logic [MASK_BITS-1:0]  step_addr,
   output      logic                  res_valid,
   output      logic [COUNT_BITS-1:0] res_data
);

   localparam int DEPTH = 1 << MASK_BITS;

   logic [COUNT_BITS-1:0] exact_ff [DEPTH];
   logic [COUNT_BITS-1:0] sub_ff   [DEPTH];
   logic [COUNT_BITS-1:0] sup_ff   [DEPTH];

   logic [COUNT_BITS-1:0] rd_exact_ff, rd_sub_ff, rd_sup_ff;
   step_type              s1_ff;
   logic [MASK_BITS-1:0]  s1_addr_ff;
   logic [COUNT_BITS-1:0] acc_ff, acc_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;

   logic [COUNT_BITS-1:0] opa, opb, sum, acc_base, wdata;
   logic                  we_exact, we_sub, we_sup, is_acc;

   localparam logic [COUNT_BITS-1:0] ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

   sms_alu #(.COUNT_BITS(COUNT_BITS)) u_alu (
      .opa (opa),
      .opb (opb),
      .neg (s1_ff.neg),
      .sum (sum)
   );

   // read port
   always_ff @(posedge clock) begin
      rd_exact_ff <= exact_ff[step_addr];
      rd_sub_ff   <= sub_ff[step_addr];
      rd_sup_ff   <= sup_ff[step_addr];
      s1_addr_ff  <= step_addr;
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else begin
         s1_ff.valid <= step.valid;
      end
      s1_ff.op         <= step.op;
      s1_ff.neg        <= step.neg;
      s1_ff.first      <= step.first;
      s1_ff.from_total <= step.from_total;
   end

   assign acc_base = s1_ff.first ? (s1_ff.from_total ? total_ff : '0) : acc_ff;

   always_comb begin
      opa    = acc_base;
      opb    = ONE;
      is_acc = 1'b0;
      case (s1_ff.op)
         OP_UPD_EXACT: opa = rd_exact_ff;
         OP_UPD_SUB:   opa = rd_sub_ff;
         OP_UPD_SUP:   opa = rd_sup_ff;
         OP_UPD_TOTAL: opa = total_ff;
         OP_ACC_EXACT: begin
            opb    = rd_exact_ff;
            is_acc = 1'b1;
         end
         OP_ACC_SUB: begin
            opb    = rd_sub_ff;
            is_acc = 1'b1;
         end
         OP_ACC_SUP: begin
            opb    = rd_sup_ff;
            is_acc = 1'b1;
         end
         default: opa = acc_base;
      endcase
   end

   assign we_exact = s1_ff.valid && (s1_ff.op == OP_CLEAR || s1_ff.op == OP_UPD_EXACT);
   assign we_sub   = s1_ff.valid && (s1_ff.op == OP_CLEAR || s1_ff.op == OP_UPD_SUB);
   assign we_sup   = s1_ff.valid && (s1_ff.op == OP_CLEAR || s1_ff.op == OP_UPD_SUP);
   assign wdata    = (s1_ff.op == OP_CLEAR) ? '0 : sum;

   // write port
   always_ff @(posedge clock) begin
      if (we_exact) exact_ff[s1_addr_ff] <= wdata;
      if (we_sub)   sub_ff[s1_addr_ff]   <= wdata;
      if (we_sup)   sup_ff[s1_addr_ff]   <= wdata;
   end

   assign acc_in   = (s1_ff.valid && is_acc) ? sum : acc_ff;
   assign total_in = (s1_ff.valid && s1_ff.op == OP_UPD_TOTAL) ? sum : total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
      acc_ff <= acc_in;
   end

   assign res_valid = s1_ff.valid && (s1_ff.op == OP_RESULT);
   assign res_data  = acc_ff;

endmodule

`default_nettype wire
